// ===== rtl/gwp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gwp_pkg;

	localparam int GRID_COLS = 32;
	localparam int GRID_ROWS = 32;
	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int CNT_W     = $clog2(GRID_COLS * GRID_ROWS + 1);
	localparam int COORD_W   = 5;
	localparam int LEN_W     = 10;
	localparam int LEN_MAX   = 1023;

	localparam logic REQ_TILE  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] MODE_ALL  = 2'd0;
	localparam logic [1:0] MODE_NOW  = 2'd1;
	localparam logic [1:0] MODE_BASE = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_UNREACH = 2'd1,
		ST_WRITTEN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FLOOD,
		S_BACK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ROW_W-1:0] wr_row;
		logic [2:0]       wr_flags;
		logic [1:0]       mode;
		logic             clr;
		logic [ROW_W-1:0] seed_row;
		logic             step;
		logic [1:0]       lvl;
	} cell_ctl_t;

	function automatic logic [1:0] inc3(input logic [1:0] v);
		logic [1:0] r;
		r = (v == 2'd2) ? 2'd0 : v + 2'd1;
		return r;
	endfunction

	function automatic logic [1:0] dec3(input logic [1:0] v);
		logic [1:0] r;
		r = (v == 2'd0) ? 2'd2 : v - 2'd1;
		return r;
	endfunction

	// bit 0 base, bit 1 free now, bit 2 free predicted
	function automatic logic passable(input logic [2:0] f, input logic [1:0] mode);
		logic p;
		p = f[0];
		if ((mode == MODE_ALL || mode == MODE_NOW) && !f[1]) p = 1'b0;
		if (mode == MODE_ALL && !f[2]) p = 1'b0;
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gwp_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gwp_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [4:0] tile_x;
	logic [4:0] tile_y;
	logic       flag_base_walkable;
	logic       flag_free_now;
	logic       flag_free_predicted;
	logic [4:0] start_col;
	logic [4:0] start_row;
	logic [4:0] goal_col;
	logic [4:0] goal_row;
	logic [1:0] pass_mode;

	modport source (
		output valid, req_type, tile_x, tile_y, flag_base_walkable, flag_free_now,
			flag_free_predicted, start_col, start_row, goal_col, goal_row, pass_mode,
		input  ready
	);
	modport sink (
		input  valid, req_type, tile_x, tile_y, flag_base_walkable, flag_free_now,
			flag_free_predicted, start_col, start_row, goal_col, goal_row, pass_mode,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/gwp_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gwp_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [9:0] path_length;
	logic [4:0] step_col;
	logic [4:0] step_row;

	modport source (output valid, status, path_length, step_col, step_row, input ready);
	modport sink (input valid, status, path_length, step_col, step_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/gwp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One grid column: flags, reached marks, wavefront and level mod 3 per row.
module gwp_cell (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire gwp_pkg::cell_ctl_t              ctl,
	input  wire logic                            wr_en,
	input  wire logic                            seed_en,
	input  wire logic [gwp_pkg::GRID_ROWS-1:0]   front_w,
	input  wire logic [gwp_pkg::GRID_ROWS-1:0]   front_e,
	output logic      [gwp_pkg::GRID_ROWS-1:0]   front,
	output logic      [gwp_pkg::GRID_ROWS-1:0]   mark,
	output logic      [1:0]                      lvl [gwp_pkg::GRID_ROWS],
	output logic                                 grow
);

	logic [2:0]                      flags_q [gwp_pkg::GRID_ROWS];
	logic [gwp_pkg::GRID_ROWS-1:0]   mark_q;
	logic [gwp_pkg::GRID_ROWS-1:0]   front_q;
	logic [1:0]                      lvl_q [gwp_pkg::GRID_ROWS];
	logic [gwp_pkg::GRID_ROWS-1:0]   new_w;

	always_comb begin
		for (int r = 0; r < gwp_pkg::GRID_ROWS; r++) begin
			logic nb;
			nb = front_w[r] | front_e[r];
			if (r > 0) nb = nb | front_q[r-1];
			if (r < gwp_pkg::GRID_ROWS - 1) nb = nb | front_q[r+1];
			new_w[r] = nb & ~mark_q[r] & gwp_pkg::passable(flags_q[r], ctl.mode);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < gwp_pkg::GRID_ROWS; r++) flags_q[r] <= 3'b000;
		end else if (wr_en) begin
			flags_q[ctl.wr_row] <= ctl.wr_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= '0;
			front_q <= '0;
		end else if (ctl.clr) begin
			mark_q  <= '0;
			front_q <= '0;
			if (seed_en) begin
				mark_q[ctl.seed_row]  <= 1'b1;
				front_q[ctl.seed_row] <= 1'b1;
			end
		end else if (ctl.step) begin
			front_q <= new_w;
			mark_q  <= mark_q | new_w;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < gwp_pkg::GRID_ROWS; r++) begin
			if (ctl.clr && seed_en && ctl.seed_row == gwp_pkg::ROW_W'(r)) begin
				lvl_q[r] <= 2'd0;
			end else if (ctl.step && new_w[r]) begin
				lvl_q[r] <= ctl.lvl;
			end
		end
	end

	assign front = front_q;
	assign mark  = mark_q;
	assign lvl   = lvl_q;
	assign grow  = |front_q;

endmodule

`default_nettype wire

// ===== rtl/grid_wavefront_path_finder_top.sv =====
// Grid path finder, Lee-style wavefront over a row of column cells.
// req channel (valid/ready): req_type 0 writes one tile's three flags,
// req_type 1 asks for a path from start to goal under pass_mode.
// rsp channel (valid/ready): one beat per req beat, in order: status,
// path_length and the first step after the start.
// Tile writes, out-of-grid queries and start equal to goal are answered
// straight from the output register. Other queries flood one wave per cycle
// until the goal is marked or the wave dies, then walk back one tile per
// cycle from the goal toward the start.
// One item is worked at a time; the walk-back and the wave loop set the rate.
// The result sits in an output register: a stalled receiver holds it, and
// the block takes the next beat once that register is free or being taken.
// Reset clears every tile's flags (all blocked) and the wavefront marks.
`timescale 1ns / 1ps
`default_nettype none

module grid_wavefront_path_finder_top (
	input  wire logic clk,
	input  wire logic arst_n,
	gwp_req_if.sink   req,
	gwp_rsp_if.source rsp
);

	localparam int COLS = gwp_pkg::GRID_COLS;
	localparam int ROWS = gwp_pkg::GRID_ROWS;
	localparam int CW   = gwp_pkg::COL_W;
	localparam int RW   = gwp_pkg::ROW_W;
	localparam int NW   = gwp_pkg::CNT_W;

	gwp_pkg::state_t    state_q, state_d;
	gwp_pkg::cell_ctl_t ctl;

	logic [CW-1:0]  gc_q, cc_q, stc_q;
	logic [RW-1:0]  gr_q, cr_q, str_q;
	logic [NW-1:0]  wave_q, k_q;
	logic [1:0]     nlvl_q, kl_q, mode_q;

	logic           rsp_v_q;
	logic [1:0]     status_q;
	logic [9:0]     len_q;
	logic [4:0]     scol_q, srow_q;

	logic [ROWS-1:0] front_a [COLS];
	logic [ROWS-1:0] mark_a  [COLS];
	logic [1:0]      lvl_a   [COLS][ROWS];
	logic [COLS-1:0] grow_v;
	logic [COLS-1:0] wr_en_v, seed_v;

	logic out_free, acc, is_tile, q_in_range, q_same, tile_in_range;
	logic goal_mark, any_front, hit;
	logic [CW-1:0] nc;
	logic [RW-1:0] nr;
	logic hit_n, hit_e, hit_s, hit_w;

	assign out_free  = !rsp_v_q || rsp.ready;
	assign req.ready = (state_q == gwp_pkg::S_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign is_tile   = (req.req_type == gwp_pkg::REQ_TILE);

	assign tile_in_range = (int'(req.tile_x) < COLS) && (int'(req.tile_y) < ROWS);
	assign q_in_range = (int'(req.start_col) < COLS) && (int'(req.start_row) < ROWS) &&
		(int'(req.goal_col) < COLS) && (int'(req.goal_row) < ROWS);
	assign q_same = (req.start_col == req.goal_col) && (req.start_row == req.goal_row);

	// column cells
	for (genvar c = 0; c < COLS; c++) begin : g_col
		logic [ROWS-1:0] fw, fe;
		if (c == 0) begin : g_w0
			assign fw = '0;
		end else begin : g_wn
			assign fw = front_a[c-1];
		end
		if (c == COLS - 1) begin : g_e0
			assign fe = '0;
		end else begin : g_en
			assign fe = front_a[c+1];
		end
		assign wr_en_v[c] = acc && is_tile && tile_in_range &&
			(req.tile_x == 5'(c));
		assign seed_v[c]  = (req.start_col == 5'(c));

		gwp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_en   (wr_en_v[c]),
			.seed_en (seed_v[c]),
			.front_w (fw),
			.front_e (fe),
			.front   (front_a[c]),
			.mark    (mark_a[c]),
			.lvl     (lvl_a[c]),
			.grow    (grow_v[c])
		);
	end

	assign goal_mark = mark_a[gc_q][gr_q];
	assign any_front = |grow_v;

	// walk-back probe, north, east, south, west
	always_comb begin
		hit_n = (cr_q != '0) && mark_a[cc_q][cr_q - 1'b1] &&
			(lvl_a[cc_q][cr_q - 1'b1] == kl_q);
		hit_e = (cc_q != CW'(COLS - 1)) && mark_a[cc_q + 1'b1][cr_q] &&
			(lvl_a[cc_q + 1'b1][cr_q] == kl_q);
		hit_s = (cr_q != RW'(ROWS - 1)) && mark_a[cc_q][cr_q + 1'b1] &&
			(lvl_a[cc_q][cr_q + 1'b1] == kl_q);
		hit_w = (cc_q != '0) && mark_a[cc_q - 1'b1][cr_q] &&
			(lvl_a[cc_q - 1'b1][cr_q] == kl_q);
		hit = hit_n || hit_e || hit_s || hit_w;
		nc  = cc_q;
		nr  = cr_q;
		if (hit_n) begin
			nr = cr_q - 1'b1;
		end else if (hit_e) begin
			nc = cc_q + 1'b1;
		end else if (hit_s) begin
			nr = cr_q + 1'b1;
		end else if (hit_w) begin
			nc = cc_q - 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gwp_pkg::S_IDLE: begin
				if (acc && !is_tile && q_in_range && !q_same) state_d = gwp_pkg::S_FLOOD;
			end
			gwp_pkg::S_FLOOD: begin
				if (goal_mark) state_d = gwp_pkg::S_BACK;
				else if (!any_front) state_d = gwp_pkg::S_DONE;
			end
			gwp_pkg::S_BACK: begin
				if (k_q == '0 || !hit) state_d = gwp_pkg::S_DONE;
			end
			gwp_pkg::S_DONE: begin
				if (out_free) state_d = gwp_pkg::S_IDLE;
			end
			default: state_d = gwp_pkg::S_IDLE;
		endcase
	end

	// cell control
	always_comb begin
		ctl          = '0;
		ctl.wr_row   = RW'(req.tile_y);
		ctl.wr_flags = {req.flag_free_predicted, req.flag_free_now, req.flag_base_walkable};
		ctl.seed_row = RW'(req.start_row);
		ctl.mode     = mode_q;
		ctl.lvl      = nlvl_q;
		case (state_q)
			gwp_pkg::S_IDLE:  ctl.clr  = acc && !is_tile && q_in_range && !q_same;
			gwp_pkg::S_FLOOD: ctl.step = !goal_mark && any_front;
			default:          ctl.step = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gwp_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gwp_pkg::S_IDLE: begin
				if (acc) begin
					gc_q   <= CW'(req.goal_col);
					gr_q   <= RW'(req.goal_row);
					mode_q <= req.pass_mode;
					wave_q <= '0;
					nlvl_q <= 2'd1;
				end
			end
			gwp_pkg::S_FLOOD: begin
				if (goal_mark) begin
					k_q   <= wave_q;
					kl_q  <= gwp_pkg::inc3(nlvl_q);
					cc_q  <= gc_q;
					cr_q  <= gr_q;
					stc_q <= gc_q;
					str_q <= gr_q;
				end else if (any_front) begin
					wave_q <= wave_q + 1'b1;
					nlvl_q <= gwp_pkg::inc3(nlvl_q);
				end else begin
					wave_q <= '0;
				end
			end
			gwp_pkg::S_BACK: begin
				if (k_q != '0 && hit) begin
					if (k_q == NW'(1)) begin
						stc_q <= cc_q;
						str_q <= cr_q;
					end
					cc_q <= nc;
					cr_q <= nr;
					k_q  <= k_q - 1'b1;
					kl_q <= gwp_pkg::dec3(kl_q);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (acc && (is_tile || !q_in_range || q_same)) begin
			rsp_v_q <= 1'b1;
		end else if (state_q == gwp_pkg::S_DONE && out_free) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= gwp_pkg::ST_UNREACH;
			len_q    <= '0;
			scol_q   <= '0;
			srow_q   <= '0;
			if (is_tile) begin
				status_q <= gwp_pkg::ST_WRITTEN;
			end else if (q_in_range && q_same) begin
				status_q <= gwp_pkg::ST_FOUND;
				scol_q   <= req.start_col;
				srow_q   <= req.start_row;
			end
		end else if (state_q == gwp_pkg::S_DONE && out_free) begin
			if (wave_q == '0) begin
				status_q <= gwp_pkg::ST_UNREACH;
				len_q    <= '0;
				scol_q   <= '0;
				srow_q   <= '0;
			end else begin
				status_q <= gwp_pkg::ST_FOUND;
				len_q    <= (int'(wave_q) > gwp_pkg::LEN_MAX) ?
					gwp_pkg::LEN_W'(gwp_pkg::LEN_MAX) : gwp_pkg::LEN_W'(wave_q);
				scol_q   <= gwp_pkg::COORD_W'(stc_q);
				srow_q   <= gwp_pkg::COORD_W'(str_q);
			end
		end
	end

	assign rsp.valid       = rsp_v_q;
	assign rsp.status      = status_q;
	assign rsp.path_length = len_q;
	assign rsp.step_col    = scol_q;
	assign rsp.step_row    = srow_q;

	// walk-back always stands on a reached tile, one level above the probe while steps remain
	a_back_on_mark: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gwp_pkg::S_BACK |-> mark_a[cc_q][cr_q])
		else $error("walk-back left the reached region");

	a_back_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gwp_pkg::S_BACK && k_q != '0) |->
			(lvl_a[cc_q][cr_q] == gwp_pkg::inc3(kl_q)))
		else $error("walk-back level out of step");

	a_back_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gwp_pkg::S_BACK && k_q != '0) |-> hit)
		else $error("walk-back found no lower neighbour");

	a_goal_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gwp_pkg::S_FLOOD && goal_mark) |=> (k_q != '0))
		else $error("goal reached at level zero");

endmodule

`default_nettype wire

// ===== verif/gwp_checker.sv =====
`timescale 1ns / 1ps

module gwp_checker
	import gwp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	gwp_req_if    req,
	gwp_rsp_if    rsp,
	output int    fail_count
);

	typedef struct {
		status_t    status;
		logic [9:0] path_length;
		logic [4:0] step_col;
		logic [4:0] step_row;
	} route_result_t;

	logic [2:0]    flags     [GRID_COLS*GRID_ROWS];
	int            tile_dist [GRID_COLS*GRID_ROWS];
	int            wave  [$];
	route_result_t pending [$];

	function automatic bit open_tile(int idx, logic [1:0] mode);
		logic [2:0] f;
		f = flags[idx];
		if (!f[0]) return 0;
		if ((mode == MODE_ALL || mode == MODE_NOW) && !f[1]) return 0;
		if (mode == MODE_ALL && !f[2]) return 0;
		return 1;
	endfunction

	function automatic bit step_to(int c, int r, int d, output int nc, output int nr);
		nc = c;
		nr = r;
		case (d)
			0: begin
				if (r == 0) return 0;
				nr = r - 1;
			end
			1: begin
				if (c + 1 >= GRID_COLS) return 0;
				nc = c + 1;
			end
			2: begin
				if (r + 1 >= GRID_ROWS) return 0;
				nr = r + 1;
			end
			default: begin
				if (c == 0) return 0;
				nc = c - 1;
			end
		endcase
		return 1;
	endfunction

	function automatic route_result_t route(int sc, int sr, int gc, int gr, logic [1:0] mode);
		route_result_t res;
		int gidx, cur, cc, cr, nc, nr, stc, str, k;
		bit moved;
		res = '{ST_UNREACH, '0, '0, '0};
		if (sc >= GRID_COLS || sr >= GRID_ROWS || gc >= GRID_COLS || gr >= GRID_ROWS)
			return res;
		if (sc == gc && sr == gr) begin
			res = '{ST_FOUND, '0, sc[4:0], sr[4:0]};
			return res;
		end
		foreach (tile_dist[i]) tile_dist[i] = -1;
		gidx = gr * GRID_COLS + gc;
		tile_dist[sr * GRID_COLS + sc] = 0;
		wave = {sr * GRID_COLS + sc};
		while (wave.size() > 0 && tile_dist[gidx] == -1) begin
			cur = wave.pop_front();
			for (int d = 0; d < 4; d++) begin
				if (!step_to(cur % GRID_COLS, cur / GRID_COLS, d, nc, nr)) continue;
				if (tile_dist[nr*GRID_COLS+nc] != -1 || !open_tile(nr*GRID_COLS+nc, mode))
					continue;
				tile_dist[nr*GRID_COLS+nc] = tile_dist[cur] + 1;
				wave.push_back(nr*GRID_COLS+nc);
			end
		end
		if (tile_dist[gidx] == -1) return res;
		cc = gc; cr = gr; stc = gc; str = gr;
		for (k = tile_dist[gidx]; k > 0; k--) begin
			moved = 0;
			for (int d = 0; d < 4 && !moved; d++) begin
				if (!step_to(cc, cr, d, nc, nr)) continue;
				if (tile_dist[nr*GRID_COLS+nc] == k - 1) begin
					if (k == 1) begin
						stc = cc; str = cr;
					end
					cc = nc; cr = nr; moved = 1;
				end
			end
			if (!moved) break;
		end
		k = tile_dist[gidx];
		res = '{ST_FOUND, (k > LEN_MAX) ? 10'(LEN_MAX) : 10'(k), stc[4:0], str[4:0]};
		return res;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		route_result_t want;
		int tx, ty;
		if (!arst_n) begin
			foreach (flags[i]) flags[i] = '0;
			pending.delete();
		end else begin
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_TILE) begin
					tx = req.tile_x;
					ty = req.tile_y;
					if (tx < GRID_COLS && ty < GRID_ROWS)
						flags[ty*GRID_COLS+tx] = {req.flag_free_predicted,
							req.flag_free_now, req.flag_base_walkable};
					pending.push_back('{ST_WRITTEN, '0, '0, '0});
				end else
					pending.push_back(route(req.start_col, req.start_row,
						req.goal_col, req.goal_row, req.pass_mode));
			end
			if (rsp.valid && rsp.ready) begin
				if (pending.size() == 0)
					report("unexpected beat", rsp.status, -1);
				else begin
					want = pending.pop_front();
					if (rsp.status !== want.status) report("status", rsp.status, want.status);
					if (rsp.path_length !== want.path_length)
						report("path_length", rsp.path_length, want.path_length);
					if (rsp.step_col !== want.step_col)
						report("step_col", rsp.step_col, want.step_col);
					if (rsp.step_row !== want.step_row)
						report("step_row", rsp.step_row, want.step_row);
				end
			end
		end
	end

	function automatic int outstanding();
		return pending.size();
	endfunction

endmodule

// ===== verif/grid_wavefront_path_finder_top_tb.sv =====
`timescale 1ns / 1ps

module grid_wavefront_path_finder_top_tb;
	import gwp_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   cycles;
	int   src_idle_pct;
	int   snk_idle_pct;

	gwp_req_if req ();
	gwp_rsp_if rsp ();

	grid_wavefront_path_finder_top dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	gwp_checker chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .fail_count(fail_count));

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= snk_idle_pct);

	task automatic send_beat(logic t, logic [4:0] a, logic [4:0] b, logic [2:0] f,
		logic [4:0] sc, logic [4:0] sr, logic [4:0] gc, logic [4:0] gr, logic [1:0] m);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.req_type <= t;
		req.tile_x <= a;
		req.tile_y <= b;
		{req.flag_free_predicted, req.flag_free_now, req.flag_base_walkable} <= f;
		req.start_col <= sc;
		req.start_row <= sr;
		req.goal_col <= gc;
		req.goal_row <= gr;
		req.pass_mode <= m;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic idle_bus();
		req.valid <= 0;
	endtask

	task automatic write_tile(int x, int y, logic [2:0] f);
		send_beat(REQ_TILE, 5'(x), 5'(y), f, 5'($urandom), 5'($urandom), 5'($urandom),
			5'($urandom), 2'($urandom));
	endtask

	task automatic query(int sc, int sr, int gc, int gr, logic [1:0] m);
		send_beat(REQ_QUERY, 5'($urandom), 5'($urandom), 3'($urandom), 5'(sc), 5'(sr),
			5'(gc), 5'(gr), m);
	endtask

	// mostly an open patch near the origin; some random flags, rare grid-wide
	task automatic random_phase(int n);
		int lim;
		for (int i = 0; i < n; i++) begin
			lim = ($urandom_range(9) == 0) ? 31 : 7;
			if ($urandom_range(99) < 55)
				write_tile($urandom_range(lim), $urandom_range(lim),
					($urandom_range(3) == 0) ? 3'($urandom) : 3'b111);
			else
				query($urandom_range(lim), $urandom_range(lim),
					$urandom_range(lim), $urandom_range(lim), 2'($urandom_range(3)));
		end
	endtask

	initial begin
		src_idle_pct = 0;
		snk_idle_pct = 0;
		arst_n = 0;
		req.valid = 0;
		req.req_type = REQ_TILE;
		req.tile_x = 0;
		req.tile_y = 0;
		req.flag_base_walkable = 0;
		req.flag_free_now = 0;
		req.flag_free_predicted = 0;
		req.start_col = 0;
		req.start_row = 0;
		req.goal_col = 0;
		req.goal_row = 0;
		req.pass_mode = 0;
		rsp.ready = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		query(3, 3, 3, 3, MODE_ALL);
		query(0, 0, 1, 0, MODE_ALL);
		query(31, 31, 31, 31, MODE_BASE);
		for (int x = 0; x < 32; x++) write_tile(x, 0, 3'b111);
		write_tile(31, 1, 3'b001);
		write_tile(31, 31, 3'b011);
		query(0, 0, 31, 0, MODE_ALL);
		query(31, 0, 0, 0, MODE_NOW);
		query(0, 0, 31, 1, MODE_ALL);
		query(0, 0, 31, 1, MODE_NOW);
		query(0, 0, 31, 1, MODE_BASE);
		query(0, 0, 31, 1, MODE_RSVD);
		query(5, 7, 0, 0, MODE_ALL);
		query(0, 0, 31, 31, MODE_BASE);
		write_tile(31, 0, 3'b000);
		query(0, 0, 31, 0, MODE_ALL);

		src_idle_pct = 26;
		snk_idle_pct = 82;
		random_phase(35);
		idle_bus();
		while (chk.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		src_idle_pct = 82;
		snk_idle_pct = 26;
		random_phase(35);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(23);
		idle_bus();

		while (chk.outstanding() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gwp_pkg.sv
rtl/gwp_req_if.sv
rtl/gwp_rsp_if.sv
rtl/gwp_cell.sv
rtl/grid_wavefront_path_finder_top.sv
verif/gwp_checker.sv
verif/grid_wavefront_path_finder_top_tb.sv
